FILE: design/qmn_pkg.sv
// Package: payload types, term tables and fixed widths for the quaternion product normaliser
`default_nettype none

package qmn_pkg;

    localparam int COMP_W = 16;
    localparam int QN_W   = 31;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int DIV_W  = 33;

    typedef struct packed {
        logic signed [COMP_W-1:0] u_w;
        logic signed [COMP_W-1:0] u_x;
        logic signed [COMP_W-1:0] u_y;
        logic signed [COMP_W-1:0] u_z;
        logic signed [COMP_W-1:0] v_w;
        logic signed [COMP_W-1:0] v_x;
        logic signed [COMP_W-1:0] v_y;
        logic signed [COMP_W-1:0] v_z;
    } t_qmn_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] r_w;
        logic signed [COMP_W-1:0] r_x;
        logic signed [COMP_W-1:0] r_y;
        logic signed [COMP_W-1:0] r_z;
        logic                     zero_magnitude;
    } t_qmn_out;

    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
    } t_side;

    localparam int TERM_V [16] = '{0, 1, 2, 3,  0, 1, 2, 3,  0, 1, 2, 3,  0, 1, 2, 3};
    localparam int TERM_U [16] = '{0, 1, 2, 3,  1, 0, 3, 2,  2, 3, 0, 1,  3, 2, 1, 0};
    localparam bit TERM_NEG [16] = '{1'b0, 1'b1, 1'b1, 1'b1,  1'b0, 1'b0, 1'b1, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b1,  1'b0, 1'b1, 1'b0, 1'b0};

endpackage

`default_nettype wire

FILE: design/quaternion_multiply_normalize_unit.sv
// Top level: pipelined Hamilton product, square root and divide to a unit quaternion
//
//  channel | direction | valid   | stall   | payload
//  input   | in        | i_valid | o_stall | i_data (u and v, Q2.14)
//  output  | out       | o_valid | i_stall | o_data (unit product, zero flag)
//
//  One transfer per cycle on each side while the pipeline is not stalled.
//  The depth is set by the 32 root stages and the FRACTION_BITS+1 quotient stages.
//  Synchronous active-low reset clears the valid bits only.
//  A held result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module quaternion_multiply_normalize_unit #(
    parameter int FRACTION_BITS = 14
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  qmn_pkg::t_qmn_in    i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output qmn_pkg::t_qmn_out   o_data
);
    import qmn_pkg::*;

    localparam int CW   = COMP_W;
    localparam int FB   = FRACTION_BITS;
    localparam int PW   = 2 * CW + 2;
    localparam int LW   = $clog2(PW + 1);
    localparam int NW   = 33 + FB;
    localparam int QOW  = FB + 1;
    localparam int NST  = 42 + FB;
    localparam int XW   = 33;
    localparam logic [XW-1:0] MAXPOS = XW'((64'(1) << (CW - 1)) - 64'(1));

    logic               en;
    logic               accept;
    logic [NST-1:0]     r_vld;

    assign en      = !r_vld[NST-1] || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], accept};
        end
    end

    logic signed [CW-1:0]   in_u [4];
    logic signed [CW-1:0]   in_v [4];

    assign in_u[0] = i_data.u_w;
    assign in_u[1] = i_data.u_x;
    assign in_u[2] = i_data.u_y;
    assign in_u[3] = i_data.u_z;
    assign in_v[0] = i_data.v_w;
    assign in_v[1] = i_data.v_x;
    assign in_v[2] = i_data.v_y;
    assign in_v[3] = i_data.v_z;

    logic signed [2*CW-1:0] r1_prod [16];
    logic signed [PW-1:0]   r2_comp [4];
    logic signed [PW-1:0]   n2_comp [4];
    logic [PW-1:0]          r3_mag  [4];
    logic [3:0]             r3_neg;
    logic [PW-1:0]          r4_mag  [4];
    logic [3:0]             r4_neg;
    logic [LW-1:0]          r4_len;
    logic [LW-1:0]          n4_len;
    logic [PW-1:0]          n4_or;
    logic [QN_W-1:0]        r5_q    [4];
    t_side                  r5_side;
    logic [2*QN_W-1:0]      r6_sq   [4];
    logic [QN_W-1:0]        r6_q    [4];
    t_side                  r6_side;

    logic [SUM_W-1:0]       r_sq_s    [0:32];
    logic [SUM_W-1:0]       r_sq_r    [0:32];
    logic [QN_W-1:0]        r_sq_q    [0:32][4];
    t_side                  r_sq_side [0:32];

    logic [NW-1:0]          r_dv_n    [0:FB+1][4];
    logic [DIV_W-1:0]       r_dv_rem  [0:FB+1][4];
    logic [QOW-1:0]         r_dv_quo  [0:FB+1][4];
    logic [DIV_W-1:0]       r_dv_d    [0:FB+1];
    t_side                  r_dv_side [0:FB+1];

    logic [ROOT_W-1:0]      root;
    logic [NW-1:0]          n_num [4];
    logic signed [CW-1:0]   n_res [4];
    t_qmn_out               r_out;

    always_comb begin
        logic signed [PW-1:0] acc;
        for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                if (TERM_NEG[4*c+k]) begin
                    acc = acc - PW'(r1_prod[4*c+k]);
                end else begin
                    acc = acc + PW'(r1_prod[4*c+k]);
                end
            end
            n2_comp[c] = acc;
        end
    end

    always_comb begin
        n4_or  = r3_mag[0] | r3_mag[1] | r3_mag[2] | r3_mag[3];
        n4_len = '0;
        for (int b = 0; b < PW; b++) begin
            if (n4_or[b]) begin
                n4_len = LW'(b + 1);
            end
        end
    end

    assign root = r_sq_r[32][ROOT_W-1:0];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_num[c] = (NW'(r_sq_q[32][c]) << (FB + 1)) + NW'(root);
        end
    end

    always_comb begin
        logic [XW-1:0] mag;
        logic [XW-1:0] sv;
        for (int c = 0; c < 4; c++) begin
            mag = XW'(r_dv_quo[FB+1][c]);
            if (r_dv_side[FB+1].neg[c]) begin
                if (mag > MAXPOS + XW'(1)) begin
                    mag = MAXPOS + XW'(1);
                end
                sv = XW'(0) - mag;
            end else begin
                if (mag > MAXPOS) begin
                    mag = MAXPOS;
                end
                sv = mag;
            end
            n_res[c] = r_dv_side[FB+1].zero ? '0 : sv[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [PW+QN_W-1:0] ext;
        if (en) begin
            for (int t = 0; t < 16; t++) begin
                r1_prod[t] <= in_v[TERM_V[t]] * in_u[TERM_U[t]];
            end
            for (int c = 0; c < 4; c++) begin
                r2_comp[c] <= n2_comp[c];
                r3_neg[c]  <= r2_comp[c][PW-1];
                r3_mag[c]  <= r2_comp[c][PW-1] ? PW'(-r2_comp[c]) : PW'(r2_comp[c]);
                r4_mag[c]  <= r3_mag[c];
                ext        = {r4_mag[c], {QN_W{1'b0}}} >> r4_len;
                r5_q[c]    <= ext[QN_W-1:0];
                r6_sq[c]   <= (2*QN_W)'(r5_q[c]) * (2*QN_W)'(r5_q[c]);
                r6_q[c]    <= r5_q[c];
                r_sq_q[0][c] <= r6_q[c];
            end
            r4_neg       <= r3_neg;
            r4_len       <= n4_len;
            r5_side.neg  <= r4_neg;
            r5_side.zero <= (r4_len == '0);
            r6_side      <= r5_side;
            r_sq_s[0]    <= SUM_W'(r6_sq[0]) + SUM_W'(r6_sq[1])
                          + SUM_W'(r6_sq[2]) + SUM_W'(r6_sq[3]);
            r_sq_r[0]    <= '0;
            r_sq_side[0] <= r6_side;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_root
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (62 - 2 * k);
        logic [SUM_W-1:0] trial;
        assign trial = r_sq_r[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_sq_s[k] >= trial) begin
                    r_sq_s[k+1] <= r_sq_s[k] - trial;
                    r_sq_r[k+1] <= (r_sq_r[k] >> 1) + BIT;
                end else begin
                    r_sq_s[k+1] <= r_sq_s[k];
                    r_sq_r[k+1] <= r_sq_r[k] >> 1;
                end
                r_sq_q[k+1]    <= r_sq_q[k];
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_dv_n[0][c]   <= n_num[c];
                r_dv_rem[0][c] <= DIV_W'(n_num[c][NW-1:FB+1]);
                r_dv_quo[0][c] <= '0;
            end
            r_dv_d[0]    <= {root, 1'b0};
            r_dv_side[0] <= r_sq_side[32];
        end
    end

    for (genvar j = 0; j <= FB; j++) begin : g_div
        localparam int IDX = FB - j;
        for (genvar c = 0; c < 4; c++) begin : g_lane
            logic [DIV_W:0] trial;
            assign trial = {r_dv_rem[j][c], r_dv_n[j][c][IDX]};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (trial >= {1'b0, r_dv_d[j]}) begin
                        r_dv_rem[j+1][c] <= DIV_W'(trial - {1'b0, r_dv_d[j]});
                        r_dv_quo[j+1][c] <= {r_dv_quo[j][c][QOW-2:0], 1'b1};
                    end else begin
                        r_dv_rem[j+1][c] <= trial[DIV_W-1:0];
                        r_dv_quo[j+1][c] <= {r_dv_quo[j][c][QOW-2:0], 1'b0};
                    end
                    r_dv_n[j+1][c] <= r_dv_n[j][c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_d[j+1]    <= r_dv_d[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.r_w            <= n_res[0];
            r_out.r_x            <= n_res[1];
            r_out.r_y            <= n_res[2];
            r_out.r_z            <= n_res[3];
            r_out.zero_magnitude <= r_dv_side[FB+1].zero;
        end
    end

    assign o_data = r_out;

    a_zero_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_magnitude |->
            o_data.r_w == '0 && o_data.r_x == '0 && o_data.r_y == '0 && o_data.r_z == '0)
        else $error("zero magnitude with nonzero components");

    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.zero_magnitude |->
            o_data.r_w != '0 || o_data.r_x != '0 || o_data.r_y != '0 || o_data.r_z != '0)
        else $error("normalised result is all zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline advanced while held");

endmodule

`default_nettype wire
